FILE: rtl/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// hrhp_pkg
// Shared types and constants of the HTTP request head parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

  // default sizes
  localparam int unsigned METHOD_BYTES_DEF = 16;
  localparam int unsigned PATH_BYTES_DEF   = 256;
  localparam int unsigned HOST_BYTES_DEF   = 256;
  localparam int unsigned BUFFER_BYTES_DEF = 65535;

  // reset value of the default port register
  localparam logic [15:0] DEFAULT_PORT_RST = 16'd80;

  // characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // result kinds
  localparam logic [1:0] KIND_METHOD  = 2'd0;
  localparam logic [1:0] KIND_PATH    = 2'd1;
  localparam logic [1:0] KIND_HOST    = 2'd2;
  localparam logic [1:0] KIND_SUMMARY = 2'd3;

  // summary status codes
  localparam logic [1:0] ST_NO_LINE    = 2'd0;
  localparam logic [1:0] ST_MALFORMED  = 2'd1;
  localparam logic [1:0] ST_UNFINISHED = 2'd2;
  localparam logic [1:0] ST_COMPLETE   = 2'd3;

  // saturation limit of the port magnitude
  localparam logic [19:0] PORT_MAX = 20'd65535;

  // one result item
  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         text_byte;
    logic [7:0]         text_index;
    logic [1:0]         status;
    logic [3:0]         method_len;
    logic [7:0]         path_len;
    logic [7:0]         host_len;
    logic signed [16:0] port;
    logic [15:0]        consumed;
    logic               final_result;
  } res_t;

endpackage

FILE: rtl/http_request_head_parser.sv
// ----------------------------------------------------------------------------
// http_request_head_parser
// Byte-serial parser of an HTTP request line and Host header.
// ----------------------------------------------------------------------------
// One request buffer streams in one byte per transfer, the final byte marked
// by in_last_byte. Method and path bytes of the request line and the bytes of
// the latest Host header value come out as tagged results while they arrive;
// the final byte also yields a summary result with status, kept lengths, port
// and consumed offset, after which the run state clears. A byte is taken in
// every cycle while input ready is high and updates the parser state. Results
// go into a four-entry output queue. A byte can cause two results (a method,
// path or host byte and the summary), so input ready drops while fewer than
// two queue entries are free. cfg_wdata sets the port that is reported when no
// host colon supplies one; it is sampled at the first byte of a run.
module http_request_head_parser #(
  parameter int unsigned METHOD_BYTES = hrhp_pkg::METHOD_BYTES_DEF,
  parameter int unsigned PATH_BYTES   = hrhp_pkg::PATH_BYTES_DEF,
  parameter int unsigned HOST_BYTES   = hrhp_pkg::HOST_BYTES_DEF,
  parameter int unsigned BUFFER_BYTES = hrhp_pkg::BUFFER_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_text_byte,
  output logic [7:0]         out_text_index,
  output logic [1:0]         out_status,
  output logic [3:0]         out_method_len,
  output logic [7:0]         out_path_len,
  output logic [7:0]         out_host_len,
  output logic signed [16:0] out_port,
  output logic [15:0]        out_consumed,
  output logic               out_final_result
);
  import hrhp_pkg::*;

  localparam int MW = (METHOD_BYTES > 2) ? $clog2(METHOD_BYTES) : 1;
  localparam int PW = (PATH_BYTES > 2) ? $clog2(PATH_BYTES) : 1;
  localparam int HW = (HOST_BYTES > 2) ? $clog2(HOST_BYTES) : 1;
  localparam int OW = $clog2(BUFFER_BYTES + 1);

  localparam logic [MW-1:0] METHOD_MAX = MW'(METHOD_BYTES - 1);
  localparam logic [PW-1:0] PATH_MAX   = PW'(PATH_BYTES - 1);
  localparam logic [HW-1:0] HOST_MAX   = HW'(HOST_BYTES - 1);
  localparam logic [OW-1:0] OFF_MAX    = OW'(BUFFER_BYTES);

  // parser phases
  localparam logic [2:0] PH_METHOD  = 3'd0;
  localparam logic [2:0] PH_PATH    = 3'd1;
  localparam logic [2:0] PH_REST    = 3'd2;
  localparam logic [2:0] PH_HEADERS = 3'd3;
  localparam logic [2:0] PH_NOLINE  = 3'd4;
  localparam logic [2:0] PH_BAD     = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;

  // header line modes
  localparam logic [1:0] HM_LINE  = 2'd0;
  localparam logic [1:0] HM_SKIP  = 2'd1;
  localparam logic [1:0] HM_BLANK = 2'd2;
  localparam logic [1:0] HM_VALUE = 2'd3;

  // port text phases
  localparam logic [1:0] PP_BLANKS = 2'd0;
  localparam logic [1:0] PP_POS    = 2'd1;
  localparam logic [1:0] PP_NEG    = 2'd2;
  localparam logic [1:0] PP_STOP   = 2'd3;

  // queue depth
  localparam int QD = 4;

  // lower-case letters of the header name, the colon is checked apart
  function automatic logic [7:0] host_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h68;
      3'd1:    c = 8'h6F;
      3'd2:    c = 8'h73;
      default: c = 8'h74;
    endcase
    return c;
  endfunction

  // parser state
  logic [2:0]         phase_r, phase_nxt;
  logic [OW-1:0]      off_r, off_nxt;
  logic [OW-1:0]      ret_r, ret_nxt;
  logic               pcr_r, pcr_nxt;
  logic [2:0]         mpos_r, mpos_nxt;
  logic [1:0]         hmode_r, hmode_nxt;
  logic [HW-1:0]      hcnt_r, hcnt_nxt;
  logic               colon_v_r, colon_v_nxt;
  logic [HW-1:0]      colon_p_r, colon_p_nxt;
  logic [15:0]        acc_r, acc_nxt;
  logic [1:0]         pphase_r, pphase_nxt;
  logic signed [16:0] port_r, port_nxt;
  logic [MW-1:0]      mcnt_r, mcnt_nxt;
  logic [PW-1:0]      pcnt_r, pcnt_nxt;
  logic [HW-1:0]      hlen_r, hlen_nxt;
  logic [15:0]        dport_r;

  // output queue
  res_t               q_mem [QD];
  logic [1:0]         wr_r;
  logic [1:0]         rd_r;
  logic [2:0]         cnt_r;

  logic               in_xfer;
  logic               out_xfer;
  logic               emit;
  res_t               text_res;
  res_t               sum_res;
  logic [1:0]         n_push;

  // working values
  logic [7:0]         b;
  logic [OW-1:0]      noff;
  logic               done;
  logic               ok;
  logic               digit;
  logic [3:0]         dval;
  logic [19:0]        prod;
  logic [1:0]         st;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign in_ready = (cnt_r <= 3'(QD - 2));

  // next state for one byte
  always_comb begin
    phase_nxt   = phase_r;
    ret_nxt     = ret_r;
    pcr_nxt     = pcr_r;
    mpos_nxt    = mpos_r;
    hmode_nxt   = hmode_r;
    hcnt_nxt    = hcnt_r;
    colon_v_nxt = colon_v_r;
    colon_p_nxt = colon_p_r;
    acc_nxt     = acc_r;
    pphase_nxt  = pphase_r;
    port_nxt    = (off_r == '0) ? $signed({1'b0, dport_r}) : port_r;
    mcnt_nxt    = mcnt_r;
    pcnt_nxt    = pcnt_r;
    hlen_nxt    = hlen_r;
    emit        = 1'b0;
    text_res    = '0;
    sum_res     = '0;
    done        = 1'b0;
    ok          = 1'b0;
    st          = ST_NO_LINE;
    prod        = '0;

    b     = in_data_byte;
    noff  = (off_r < OFF_MAX) ? off_r + 1'b1 : off_r;
    digit = (b >= CH_ZERO) && (b <= CH_NINE);
    dval  = 4'(b - CH_ZERO);

    if (phase_r <= PH_REST) begin
      // request line
      if (pcr_r) begin
        pcr_nxt = 1'b0;
        if (b != CH_LF) begin
          phase_nxt = PH_NOLINE;
        end else if (phase_r == PH_REST) begin
          phase_nxt = PH_HEADERS;
          hmode_nxt = HM_LINE;
          mpos_nxt  = '0;
          ret_nxt   = noff;
        end else begin
          phase_nxt = PH_BAD;
        end
      end else if (b == CH_CR) begin
        pcr_nxt = 1'b1;
      end else if (phase_r == PH_METHOD) begin
        if (b == CH_SPACE) begin
          phase_nxt = PH_PATH;
        end else if (mcnt_r < METHOD_MAX) begin
          emit                = 1'b1;
          text_res.kind       = KIND_METHOD;
          text_res.text_byte  = b;
          text_res.text_index = 8'(mcnt_r);
          mcnt_nxt            = mcnt_r + 1'b1;
        end
      end else if (phase_r == PH_PATH) begin
        if (b == CH_SPACE) begin
          phase_nxt = PH_REST;
        end else if (pcnt_r < PATH_MAX) begin
          emit                = 1'b1;
          text_res.kind       = KIND_PATH;
          text_res.text_byte  = b;
          text_res.text_index = 8'(pcnt_r);
          pcnt_nxt            = pcnt_r + 1'b1;
        end
      end
    end else if (phase_r == PH_HEADERS) begin
      // end of head or a stray cr
      if (pcr_r) begin
        pcr_nxt = 1'b0;
        if (b == CH_LF) begin
          phase_nxt = PH_DONE;
          done      = 1'b1;
        end else begin
          hmode_nxt = HM_SKIP;
        end
      end
      // header name match at line start
      if (!done && hmode_nxt == HM_LINE) begin
        if (mpos_r == 3'd0 && b == CH_CR) begin
          pcr_nxt = 1'b1;
          done    = 1'b1;
        end else begin
          ok = (mpos_r < 3'd4) ? ((b | 8'h20) == host_char(mpos_r)) : (b == CH_COLON);
          if (ok) begin
            done = 1'b1;
            if (mpos_r == 3'd4) begin
              mpos_nxt    = '0;
              hmode_nxt   = HM_BLANK;
              ret_nxt     = noff;
              hcnt_nxt    = '0;
              colon_v_nxt = 1'b0;
              hlen_nxt    = '0;
              acc_nxt     = '0;
              pphase_nxt  = PP_BLANKS;
            end else begin
              mpos_nxt = mpos_r + 1'b1;
            end
          end else begin
            mpos_nxt  = '0;
            hmode_nxt = HM_SKIP;
          end
        end
      end
      // rest of a line that is not a host header
      if (!done && hmode_nxt == HM_SKIP) begin
        done = 1'b1;
        if (b == CH_LF) begin
          hmode_nxt = HM_LINE;
          mpos_nxt  = '0;
          ret_nxt   = noff;
        end
      end
      // blanks ahead of the host value
      if (!done && hmode_nxt == HM_BLANK) begin
        if (b == CH_SPACE || b == CH_TAB) begin
          ret_nxt = noff;
          done    = 1'b1;
        end else begin
          hmode_nxt = HM_VALUE;
        end
      end
      // host value bytes
      if (!done) begin
        if (b == CH_CR) begin
          hmode_nxt = HM_SKIP;
        end else if (b == CH_LF) begin
          hmode_nxt = HM_LINE;
          mpos_nxt  = '0;
          ret_nxt   = noff;
        end else if (hcnt_nxt < HOST_MAX) begin
          emit                = 1'b1;
          text_res.kind       = KIND_HOST;
          text_res.text_byte  = b;
          text_res.text_index = 8'(hcnt_nxt);
          if (b == CH_COLON) begin
            colon_v_nxt = 1'b1;
            colon_p_nxt = hcnt_nxt;
            acc_nxt     = '0;
            pphase_nxt  = PP_BLANKS;
            port_nxt    = '0;
          end else if (colon_v_nxt) begin
            // port text after the last colon
            if (pphase_nxt == PP_BLANKS) begin
              if (!(b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF)) begin
                if (b == CH_PLUS) begin
                  pphase_nxt = PP_POS;
                end else if (b == CH_MINUS) begin
                  pphase_nxt = PP_NEG;
                end else if (digit) begin
                  pphase_nxt = PP_POS;
                  acc_nxt    = 16'(dval);
                end else begin
                  pphase_nxt = PP_STOP;
                end
                port_nxt = (pphase_nxt == PP_NEG) ? -$signed({1'b0, acc_nxt})
                                                  : $signed({1'b0, acc_nxt});
              end
            end else begin
              if (pphase_nxt != PP_STOP) begin
                if (digit) begin
                  prod    = 20'(acc_nxt) * 20'd10 + 20'(dval);
                  acc_nxt = (prod > PORT_MAX) ? 16'(PORT_MAX) : 16'(prod);
                end else begin
                  pphase_nxt = PP_STOP;
                end
              end
              port_nxt = (pphase_nxt == PP_NEG) ? -$signed({1'b0, acc_nxt})
                                                : $signed({1'b0, acc_nxt});
            end
          end
          hcnt_nxt = hcnt_nxt + 1'b1;
          hlen_nxt = colon_v_nxt ? colon_p_nxt : hcnt_nxt;
        end
      end
    end

    off_nxt = noff;

    // summary at the last byte
    unique case (phase_nxt)
      PH_BAD:     st = ST_MALFORMED;
      PH_HEADERS: st = ST_UNFINISHED;
      PH_DONE:    st = ST_COMPLETE;
      default:    st = ST_NO_LINE;
    endcase
    sum_res.kind         = KIND_SUMMARY;
    sum_res.status       = st;
    sum_res.port         = port_nxt;
    sum_res.final_result = 1'b1;
    if (st == ST_UNFINISHED || st == ST_COMPLETE) begin
      sum_res.method_len = 4'(mcnt_nxt);
      sum_res.path_len   = 8'(pcnt_nxt);
      sum_res.host_len   = 8'(hlen_nxt);
      sum_res.consumed   = 16'(ret_nxt);
    end

    // run state clears after the last byte
    if (in_last_byte) begin
      phase_nxt   = PH_METHOD;
      off_nxt     = '0;
      ret_nxt     = '0;
      pcr_nxt     = 1'b0;
      mpos_nxt    = '0;
      hmode_nxt   = HM_LINE;
      hcnt_nxt    = '0;
      colon_v_nxt = 1'b0;
      acc_nxt     = '0;
      pphase_nxt  = PP_BLANKS;
      port_nxt    = $signed({1'b0, dport_r});
      mcnt_nxt    = '0;
      pcnt_nxt    = '0;
      hlen_nxt    = '0;
    end
  end

  assign n_push = in_xfer ? (2'(emit) + 2'(in_last_byte)) : 2'd0;

  // parser and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_METHOD;
      off_r     <= '0;
      ret_r     <= '0;
      pcr_r     <= 1'b0;
      mpos_r    <= '0;
      hmode_r   <= HM_LINE;
      hcnt_r    <= '0;
      colon_v_r <= 1'b0;
      colon_p_r <= '0;
      acc_r     <= '0;
      pphase_r  <= PP_BLANKS;
      port_r    <= $signed({1'b0, DEFAULT_PORT_RST});
      mcnt_r    <= '0;
      pcnt_r    <= '0;
      hlen_r    <= '0;
      dport_r   <= DEFAULT_PORT_RST;
    end else begin
      if (cfg_we) begin
        dport_r <= cfg_wdata;
      end
      if (in_xfer) begin
        phase_r   <= phase_nxt;
        off_r     <= off_nxt;
        ret_r     <= ret_nxt;
        pcr_r     <= pcr_nxt;
        mpos_r    <= mpos_nxt;
        hmode_r   <= hmode_nxt;
        hcnt_r    <= hcnt_nxt;
        colon_v_r <= colon_v_nxt;
        colon_p_r <= colon_p_nxt;
        acc_r     <= acc_nxt;
        pphase_r  <= pphase_nxt;
        port_r    <= port_nxt;
        mcnt_r    <= mcnt_nxt;
        pcnt_r    <= pcnt_nxt;
        hlen_r    <= hlen_nxt;
      end
    end
  end

  // output queue storage, first entry is the text result when there is one
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (emit) begin
        q_mem[wr_r] <= text_res;
        if (in_last_byte) begin
          q_mem[wr_r + 2'd1] <= sum_res;
        end
      end else if (in_last_byte) begin
        q_mem[wr_r] <= sum_res;
      end
    end
  end

  // output queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + n_push;
      rd_r  <= rd_r + 2'(out_xfer);
      cnt_r <= cnt_r + 3'(n_push) - 3'(out_xfer);
    end
  end

  // result channel
  assign out_valid        = (cnt_r != '0);
  assign out_kind         = q_mem[rd_r].kind;
  assign out_text_byte    = q_mem[rd_r].text_byte;
  assign out_text_index   = q_mem[rd_r].text_index;
  assign out_status       = q_mem[rd_r].status;
  assign out_method_len   = q_mem[rd_r].method_len;
  assign out_path_len     = q_mem[rd_r].path_len;
  assign out_host_len     = q_mem[rd_r].host_len;
  assign out_port         = q_mem[rd_r].port;
  assign out_consumed     = q_mem[rd_r].consumed;
  assign out_final_result = q_mem[rd_r].final_result;

`ifndef SYNTH
  // queue never overfills
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(QD))
    else $error("output queue over capacity");

  // the last byte of a run clears the offset
  a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_last_byte) |=> (off_r == '0) && (phase_r == PH_METHOD))
    else $error("run state not cleared after last byte");

  // only the summary carries the final flag
  a_final_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_final_result == (out_kind == KIND_SUMMARY)))
    else $error("final flag and result kind disagree");

  // an accepted last byte always lands its summary result in the queue
  a_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_last_byte && !out_xfer) |=> (cnt_r != '0))
    else $error("summary result lost");
`endif

endmodule
